[rtl/gprb_pkg.sv]
// gprb_pkg: shared types and constants for the gpio port register block
// no dependencies; imported by every module in rtl/

package gprb_pkg;

  localparam int NUM_PORTS  = 15;
  localparam int PORT_IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  typedef enum logic [2:0] {
    GRP_DIR  = 3'd0,
    GRP_DATA = 3'd1,
    GRP_PIN  = 3'd2,
    GRP_ICTL = 3'd3,
    GRP_OD   = 3'd4
  } group_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RO       = 2'd1,
    ST_UNMAPPED = 2'd2
  } status_t;

  typedef struct packed {
    logic       command;
    logic [7:0] offset;
    logic [7:0] write_data;
    logic [7:0] pin_levels;
  } request_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] port_index;
    logic [7:0] drive_enable;
    logic [7:0] drive_high;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [7:0] dir;
    logic [7:0] data;
    logic [7:0] ictl;
    logic [7:0] od;
  } port_view_t;

  typedef struct packed {
    logic                  en;
    group_t                group;
    logic [PORT_IDX_W-1:0] idx;
    logic [7:0]            data;
  } bank_wr_t;

endpackage

[rtl/gprb_bank.sv]
// gprb_bank: per-port direction, data, input control and open-drain registers
// depends on gprb_pkg; one write port, one combinational read port

module gprb_bank
  import gprb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  bank_wr_t              wr,
  input  logic [PORT_IDX_W-1:0] rd_idx,
  output port_view_t            view
);

  logic [7:0] dir_regs  [NUM_PORTS];
  logic [7:0] data_regs [NUM_PORTS];
  logic [7:0] ictl_regs [NUM_PORTS];
  logic [7:0] od_regs   [NUM_PORTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        dir_regs[i]  <= '0;
        data_regs[i] <= '0;
        ictl_regs[i] <= '0;
        od_regs[i]   <= '0;
      end
    end else if (wr.en) begin
      unique case (wr.group)
        GRP_DIR:  dir_regs[wr.idx]  <= wr.data;
        GRP_DATA: data_regs[wr.idx] <= wr.data;
        GRP_ICTL: ictl_regs[wr.idx] <= wr.data;
        GRP_OD:   od_regs[wr.idx]   <= wr.data;
        default: ;
      endcase
    end
  end

  assign view.dir  = dir_regs[rd_idx];
  assign view.data = data_regs[rd_idx];
  assign view.ictl = ictl_regs[rd_idx];
  assign view.od   = od_regs[rd_idx];

endmodule

[rtl/gprb_access.sv]
// gprb_access: offset decode, read mux, write request and pin drive logic
// depends on gprb_pkg; purely combinational, sits between the two registers

module gprb_access
  import gprb_pkg::*;
(
  input  request_t              req,
  input  logic                  fire,
  input  port_view_t            view,
  output logic [PORT_IDX_W-1:0] rd_idx,
  output bank_wr_t              wr,
  output result_t               res
);

  logic [2:0] group_raw;
  group_t     group;
  logic [4:0] port;
  logic       unmapped;
  logic [7:0] dir_new;
  logic [7:0] data_new;
  logic [7:0] od_new;
  logic [7:0] enable;
  logic [7:0] rdata;
  logic       ro_write;

  assign group_raw = req.offset[7:5];
  assign group     = group_t'(group_raw);
  assign port      = req.offset[4:0];
  assign unmapped  = (group_raw > GRP_OD) || ({1'b0, port} >= 6'(NUM_PORTS));
  assign rd_idx    = port[PORT_IDX_W-1:0];
  assign ro_write  = req.command && (group == GRP_PIN);

  assign wr.en    = fire && req.command && !unmapped && (group != GRP_PIN);
  assign wr.group = group;
  assign wr.idx   = rd_idx;
  assign wr.data  = req.write_data;

  // drive reflects this transaction's own write
  assign dir_new  = (req.command && group == GRP_DIR)  ? req.write_data : view.dir;
  assign data_new = (req.command && group == GRP_DATA) ? req.write_data : view.data;
  assign od_new   = (req.command && group == GRP_OD)   ? req.write_data : view.od;
  assign enable   = dir_new & ~(data_new & od_new);

  always_comb begin
    unique case (group)
      GRP_DIR:  rdata = view.dir;
      GRP_DATA: rdata = view.data;
      GRP_PIN:  rdata = req.pin_levels;
      GRP_ICTL: rdata = view.ictl;
      GRP_OD:   rdata = view.od;
      default:  rdata = '0;
    endcase
  end

  always_comb begin
    if (unmapped) begin
      res = '0;
      res.status = ST_UNMAPPED;
    end else begin
      res.read_data    = req.command ? 8'h00 : rdata;
      res.port_index   = port[3:0];
      res.drive_enable = enable;
      res.drive_high   = data_new & enable;
      res.status       = ro_write ? ST_RO : ST_OK;
    end
  end

endmodule

[rtl/gpio_port_register_block.sv]
// gpio_port_register_block: top level, input register, output register, handshake
// depends on gprb_pkg, gprb_bank and gprb_access
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------
//   request | req_valid | req_stall | req (request_t)
//   result  | rsp_valid | rsp_stall | rsp (result_t)
//
// one transaction per cycle unless stalled; result passes through both registers
// register writes land at the same edge the result is registered
// rst is synchronous and clears all port registers to zero
// a stalled result holds the input register, which then raises req_stall

module gpio_port_register_block
  import gprb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  request_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output result_t  rsp
);

  logic                  stage_valid;
  request_t              stage;
  logic                  out_free;
  logic                  fire;
  logic [PORT_IDX_W-1:0] rd_idx;
  bank_wr_t              wr;
  port_view_t            view;
  result_t               res;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign fire      = stage_valid && out_free;
  assign req_stall = stage_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!req_stall) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      stage <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= res;
    end
  end

  gprb_bank u_bank (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd_idx (rd_idx),
    .view   (view)
  );

  gprb_access u_access (
    .req    (stage),
    .fire   (fire),
    .view   (view),
    .rd_idx (rd_idx),
    .wr     (wr),
    .res    (res)
  );

endmodule

[tb/sv/gpio_port_register_block_tb.sv]
// gpio_port_register_block_tb: self-checking testbench for the gpio port register block
// depends on gprb_pkg and gpio_port_register_block; a scoreboard class predicts every
// transaction and checks the results, with random gaps on requests and stalls on results

`timescale 1ns / 1ps

import gprb_pkg::*;

localparam logic CMD_READ  = 1'b0;
localparam logic CMD_WRITE = 1'b1;

class port_access_scoreboard;
  bit [7:0] port_dir  [NUM_PORTS];
  bit [7:0] port_data [NUM_PORTS];
  bit [7:0] port_ictl [NUM_PORTS];
  bit [7:0] port_od   [NUM_PORTS];
  result_t  expected_results[$];
  int       errors;
  int       checked;
  int       writes;
  int       reads;
  int       unmapped;

  task report(string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function void note_access(request_t a);
    result_t    r;
    logic [2:0] grp;
    logic [4:0] port;
    logic [3:0] idx;
    bit [7:0]   en;
    r    = '0;
    grp  = a.offset[7:5];
    port = a.offset[4:0];
    idx  = port[3:0];
    if (grp > GRP_OD || port >= NUM_PORTS) begin
      r.status = ST_UNMAPPED;
      unmapped++;
    end else begin
      r.status = ST_OK;
      if (a.command == CMD_WRITE) begin
        writes++;
        case (group_t'(grp))
          GRP_DIR:  port_dir[idx] = a.write_data;
          GRP_DATA: port_data[idx] = a.write_data;
          GRP_PIN:  r.status = ST_RO;
          GRP_ICTL: port_ictl[idx] = a.write_data;
          default:  port_od[idx] = a.write_data;
        endcase
      end else begin
        reads++;
        case (group_t'(grp))
          GRP_DIR:  r.read_data = port_dir[idx];
          GRP_DATA: r.read_data = port_data[idx];
          GRP_PIN:  r.read_data = a.pin_levels;
          GRP_ICTL: r.read_data = port_ictl[idx];
          default:  r.read_data = port_od[idx];
        endcase
      end
      // open-drain high releases the pin
      en = port_dir[idx] & ~(port_data[idx] & port_od[idx]);
      r.port_index   = idx;
      r.drive_enable = en;
      r.drive_high   = port_data[idx] & en;
    end
    expected_results.push_back(r);
  endfunction

  task check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report($sformatf("transaction %0d: %s got %h expected %h", checked, name, got, want));
  endtask

  task check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      report($sformatf("result %h with no transaction pending", got));
      return;
    end
    want = expected_results.pop_front();
    checked++;
    check_field("read_data", got.read_data, want.read_data);
    check_field("port_index", {4'h0, got.port_index}, {4'h0, want.port_index});
    check_field("drive_enable", got.drive_enable, want.drive_enable);
    check_field("drive_high", got.drive_high, want.drive_high);
    check_field("status", {6'h00, got.status}, {6'h00, want.status});
  endtask
endclass

module gpio_port_register_block_tb;
  import gprb_pkg::*;

  localparam int NUM_RANDOM = 1750;
  localparam int IDLE_LIMIT = 1000;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  request_t req;
  logic     rsp_valid;
  logic     rsp_stall;
  result_t  rsp;

  port_access_scoreboard sb = new;
  int burst_left = 0;

  gpio_port_register_block u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] reg_offset(group_t g, int p);
    return {g, p[4:0]};
  endfunction

  function automatic request_t make_access(logic cmd, logic [7:0] off, logic [7:0] wd,
                                           logic [7:0] pins);
    request_t a;
    a.command    = cmd;
    a.offset     = off;
    a.write_data = wd;
    a.pin_levels = pins;
    return a;
  endfunction

  task send_access(request_t a);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req       <= a;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    burst_left--;
  endtask

  // result stall pattern is chosen at random among four modes
  initial begin : result_stall
    int mode;
    int cnt;
    mode = 0;
    cnt  = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cnt++;
      if (cnt % 200 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       rsp_stall <= 1'b0;
        1:       rsp_stall <= ($urandom_range(0, 2) == 0);
        2:       rsp_stall <= ((cnt % 8) >= 5);
        default: rsp_stall <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) sb.note_access(req);
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
      else idle++;
    end
    $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] off;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: low and high port, every register, error offsets
    send_access(make_access(CMD_READ,  reg_offset(GRP_DIR, 0),   8'h00, 8'h00));
    send_access(make_access(CMD_WRITE, reg_offset(GRP_DIR, 0),   8'hFF, 8'h00));
    send_access(make_access(CMD_WRITE, reg_offset(GRP_DATA, 0),  8'hA5, 8'hFF));
    send_access(make_access(CMD_WRITE, reg_offset(GRP_OD, 0),    8'h0F, 8'h00));
    send_access(make_access(CMD_READ,  reg_offset(GRP_OD, 0),    8'h00, 8'hFF));
    send_access(make_access(CMD_READ,  reg_offset(GRP_DATA, 0),  8'h00, 8'h00));
    send_access(make_access(CMD_WRITE, reg_offset(GRP_ICTL, 0),  8'hFF, 8'h00));
    send_access(make_access(CMD_READ,  reg_offset(GRP_ICTL, 0),  8'h00, 8'h00));
    send_access(make_access(CMD_READ,  reg_offset(GRP_PIN, 0),   8'h00, 8'hFF));
    send_access(make_access(CMD_READ,  reg_offset(GRP_PIN, 0),   8'hFF, 8'h00));
    send_access(make_access(CMD_WRITE, reg_offset(GRP_PIN, 0),   8'hFF, 8'hFF));
    send_access(make_access(CMD_WRITE, reg_offset(GRP_DIR, 14),  8'h55, 8'h00));
    send_access(make_access(CMD_WRITE, reg_offset(GRP_DATA, 14), 8'hFF, 8'h00));
    send_access(make_access(CMD_WRITE, reg_offset(GRP_OD, 14),   8'hFF, 8'h00));
    send_access(make_access(CMD_READ,  reg_offset(GRP_DIR, 14),  8'h00, 8'h00));
    send_access(make_access(CMD_WRITE, reg_offset(GRP_OD, 14),   8'h00, 8'h00));
    send_access(make_access(CMD_WRITE, reg_offset(GRP_DIR, 15),  8'hFF, 8'hFF));
    send_access(make_access(CMD_READ,  reg_offset(GRP_DIR, 31),  8'h00, 8'hFF));
    send_access(make_access(CMD_WRITE, 8'hA0,                    8'hFF, 8'hFF));
    send_access(make_access(CMD_READ,  8'hFF,                    8'h00, 8'hFF));
    send_access(make_access(CMD_READ,  reg_offset(GRP_OD, 31),   8'h00, 8'h00));
    send_access(make_access(CMD_WRITE, reg_offset(GRP_DATA, 14), 8'h00, 8'h00));
    send_access(make_access(CMD_READ,  reg_offset(GRP_DATA, 14), 8'h00, 8'h00));
    send_access(make_access(CMD_WRITE, reg_offset(GRP_ICTL, 14), 8'h00, 8'hFF));

    // random: mostly mapped offsets, some anywhere in the byte range
    repeat (NUM_RANDOM) begin
      if ($urandom_range(0, 9) == 0) off = 8'($urandom_range(0, 255));
      else off = reg_offset(group_t'($urandom_range(0, 4)), $urandom_range(0, NUM_PORTS - 1));
      send_access(make_access(1'($urandom_range(0, 1)), off, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255))));
    end
    req_valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d accesses: %0d writes, %0d reads, %0d unmapped",
             sb.writes + sb.reads + sb.unmapped, sb.writes, sb.reads, sb.unmapped);
    $display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
